// File: rtl/cvkt_pkg.sv
// ----------------------------------------------------------------------------
// cvkt_pkg
// Shared types, constants and saturation helpers for the constant-velocity
// tracker.
// ----------------------------------------------------------------------------
package cvkt_pkg;

  localparam int CfgW = 31;
  localparam int CfgIdxW = 2;
  localparam int DivSteps = 2;
  localparam int DivBits = 56;
  localparam int DivCycles = DivBits / DivSteps;
  localparam int DivCntW = $clog2(DivCycles);

  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_COV = 2'd2;

  localparam logic [CfgW-1:0] PROCESS_NOISE_RST = 31'd1678;
  localparam logic [CfgW-1:0] MEASURE_NOISE_RST = 31'd167772;
  localparam logic [CfgW-1:0] INITIAL_COV_RST = 31'd1677722;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;
  localparam logic signed [33:0] ONE_Q24 = 34'sd16777216;

  // control strobes from the sequencer to the lanes and the covariance unit
  typedef struct packed {
    logic pred_en;
    logic start;
    logic err_en;
    logic mul_en;
    logic upd_en;
  } cvkt_ctl_t;

  // sign extend a 32-bit value to 64 bits
  function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

  // saturate a 64-bit value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > MAX32) begin
      sat32 = 32'sh7fffffff;
    end else if (v < MIN32) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// File: rtl/cvkt_ifs.sv
// ----------------------------------------------------------------------------
// cvkt channel interfaces
// Valid/ready channels for measured points and predicted positions.
// ----------------------------------------------------------------------------
interface cvkt_meas_if;
  logic valid;
  logic ready;
  logic signed [15:0] meas_x;
  logic signed [15:0] meas_y;
  logic start_req;
  modport source (output valid, meas_x, meas_y, start_req, input ready);
  modport sink (input valid, meas_x, meas_y, start_req, output ready);
endinterface

interface cvkt_pred_if;
  logic valid;
  logic ready;
  logic signed [15:0] pred_x;
  logic signed [15:0] pred_y;
  modport source (output valid, pred_x, pred_y, input ready);
  modport sink (input valid, pred_x, pred_y, output ready);
endinterface

// File: rtl/cvkt_div.sv
// ----------------------------------------------------------------------------
// cvkt_div
// Iterative signed gain divider: num * 2^24 / den, two quotient bits a cycle,
// result saturated to 32 bits.
// ----------------------------------------------------------------------------
module cvkt_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  num,
  input  logic [32:0]         den,
  output logic                busy,
  output logic signed [31:0]  quo
);

  logic [33:0] rem;
  logic [33:0] rem_next;
  logic [cvkt_pkg::DivBits-1:0] sh;
  logic [cvkt_pkg::DivBits-1:0] sh_next;
  logic [cvkt_pkg::DivCntW-1:0] cnt;
  logic [32:0] dsr;
  logic neg;
  logic [31:0] mag_in;

  assign mag_in = num[31] ? (~num + 32'd1) : num;

  // two restoring steps per cycle
  always_comb begin
    logic [33:0] r;
    logic [cvkt_pkg::DivBits-1:0] s;
    logic ge;
    r = rem;
    s = sh;
    for (int i = 0; i < cvkt_pkg::DivSteps; i++) begin
      r = {r[32:0], s[cvkt_pkg::DivBits-1]};
      ge = (r >= {1'b0, dsr});
      if (ge) begin
        r = r - {1'b0, dsr};
      end
      s = {s[cvkt_pkg::DivBits-2:0], ge};
    end
    rem_next = r;
    sh_next = s;
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= cvkt_pkg::DivCntW'(cvkt_pkg::DivCycles - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      sh <= {mag_in, 24'd0};
      dsr <= den;
      neg <= num[31];
    end else if (busy) begin
      rem <= rem_next;
      sh <= sh_next;
    end
  end

  // sign and saturate the quotient
  always_comb begin
    if (neg) begin
      if (sh > cvkt_pkg::DivBits'(64'd2147483648)) begin
        quo = 32'sh80000000;
      end else begin
        quo = 32'(~sh[31:0] + 32'd1);
      end
    end else if (sh > cvkt_pkg::DivBits'(64'd2147483647)) begin
      quo = 32'sh7fffffff;
    end else begin
      quo = sh[31:0];
    end
  end

endmodule

// File: rtl/cvkt_lane.sv
// ----------------------------------------------------------------------------
// cvkt_lane
// One axis of the tracker: position and velocity estimate, predict and
// correct.
// ----------------------------------------------------------------------------
module cvkt_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  cvkt_pkg::cvkt_ctl_t  ctl,
  input  logic signed [15:0]   meas,
  input  logic signed [31:0]   k0,
  input  logic signed [31:0]   k1,
  output logic signed [15:0]   pred_int
);

  logic signed [31:0] pos;
  logic signed [31:0] vel;
  logic signed [31:0] err;
  logic signed [63:0] prod_p;
  logic signed [63:0] prod_v;
  logic signed [31:0] meas_q;
  logic signed [31:0] pos_pred;
  logic signed [31:0] pos_base;
  logic signed [31:0] vel_base;
  logic signed [15:0] floor_int;

  assign meas_q = {meas, 16'd0};
  assign pos_base = ctl.start ? meas_q : pos;
  assign vel_base = ctl.start ? 32'sd0 : vel;
  assign pos_pred = cvkt_pkg::sat32(cvkt_pkg::sx32(pos_base) + cvkt_pkg::sx32(vel_base));

  // truncate toward zero
  assign floor_int = pos_pred[31:16];
  assign pred_int = (pos_pred[31] && (pos_pred[15:0] != 16'd0)) ?
                    floor_int + 16'sd1 : floor_int;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else if (ctl.pred_en) begin
      pos <= pos_pred;
      vel <= vel_base;
    end else if (ctl.upd_en) begin
      pos <= cvkt_pkg::sat32(cvkt_pkg::sx32(pos) + (prod_p >>> 24));
      vel <= cvkt_pkg::sat32(cvkt_pkg::sx32(vel) + (prod_v >>> 24));
    end
  end

  // innovation and gain products
  always_ff @(posedge clk) begin
    if (ctl.err_en) begin
      err <= cvkt_pkg::sat32(cvkt_pkg::sx32(meas_q) - cvkt_pkg::sx32(pos));
    end
    if (ctl.mul_en) begin
      prod_p <= cvkt_pkg::sx32(k0) * cvkt_pkg::sx32(err);
      prod_v <= cvkt_pkg::sx32(k1) * cvkt_pkg::sx32(err);
    end
  end

endmodule

// File: rtl/cvkt_cov.sv
// ----------------------------------------------------------------------------
// cvkt_cov
// Shared 2x2 error covariance: predict, innovation variance, correct.
// ----------------------------------------------------------------------------
module cvkt_cov (
  input  logic                 clk,
  input  logic                 rst,
  input  cvkt_pkg::cvkt_ctl_t  ctl,
  input  logic [30:0]          q,
  input  logic [30:0]          r,
  input  logic [30:0]          init_cov,
  input  logic signed [31:0]   k0,
  input  logic signed [31:0]   k1,
  output logic signed [31:0]   cov_a,
  output logic signed [31:0]   cov_b,
  output logic [32:0]          s_den,
  output logic                 s_pos
);

  logic signed [31:0] cov_c;
  logic signed [31:0] a0;
  logic signed [31:0] b0;
  logic signed [31:0] c0;
  logic signed [63:0] q64;
  logic signed [63:0] s64;
  logic signed [63:0] om64;
  logic signed [63:0] prod_a;
  logic signed [63:0] prod_b;
  logic signed [63:0] prod_c;

  assign a0 = ctl.start ? {1'b0, init_cov} : cov_a;
  assign b0 = ctl.start ? 32'sd0 : cov_b;
  assign c0 = ctl.start ? {1'b0, init_cov} : cov_c;
  assign q64 = {33'd0, q};
  assign s64 = cvkt_pkg::sx32(cov_a) + {33'd0, r};
  assign s_pos = (s64 > 64'sd0);
  assign s_den = s64[32:0];
  assign om64 = {{30{cvkt_pkg::ONE_Q24[33]}}, cvkt_pkg::ONE_Q24} - cvkt_pkg::sx32(k0);

  // covariance state
  always_ff @(posedge clk) begin
    if (rst) begin
      cov_a <= '0;
      cov_b <= '0;
      cov_c <= '0;
    end else if (ctl.pred_en) begin
      cov_a <= cvkt_pkg::sat32(cvkt_pkg::sx32(a0) + (cvkt_pkg::sx32(b0) <<< 1) +
                               cvkt_pkg::sx32(c0) + q64);
      cov_b <= cvkt_pkg::sat32(cvkt_pkg::sx32(b0) + cvkt_pkg::sx32(c0));
      cov_c <= cvkt_pkg::sat32(cvkt_pkg::sx32(c0) + q64);
    end else if (ctl.upd_en) begin
      cov_a <= cvkt_pkg::sat32(prod_a >>> 24);
      cov_b <= cvkt_pkg::sat32(prod_b >>> 24);
      cov_c <= cvkt_pkg::sat32(cvkt_pkg::sx32(cov_c) - (prod_c >>> 24));
    end
  end

  // correction products
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_a <= cvkt_pkg::sx32(cov_a) * om64;
      prod_b <= cvkt_pkg::sx32(cov_b) * om64;
      prod_c <= cvkt_pkg::sx32(k1) * cvkt_pkg::sx32(cov_b);
    end
  end

endmodule

// File: rtl/constant_velocity_kalman_tracker.sv
// ----------------------------------------------------------------------------
// constant_velocity_kalman_tracker
// 2-D constant-velocity Kalman tracker: an x lane and a y lane share one
// covariance unit and two gain dividers; the output register merges the lanes.
// ----------------------------------------------------------------------------
//  channel  dir   handshake      payload
//  meas     in    valid/ready    meas_x, meas_y, start_req
//  pred     out   valid/ready    pred_x, pred_y
//  cfg      in    cfg_we         cfg_index, cfg_data
//
// one transaction at a time; the gain dividers dominate the time from accept to
// the next ready (56 quotient bits, two per cycle, in the divide step); the
// dividers are not started when a + r is not positive
// the prediction is emitted early; a stalled pred channel holds the sequencer
// in its predict step until the output register frees
// synchronous reset clears the state estimate and loads default noise values
module constant_velocity_kalman_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [30:0]          cfg_data,
  cvkt_meas_if.sink            meas,
  cvkt_pred_if.source          pred
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PRED   = 6'b000010,
    S_LAUNCH = 6'b000100,
    S_DIV    = 6'b001000,
    S_MUL    = 6'b010000,
    S_UPD    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  cvkt_pkg::cvkt_ctl_t ctl;

  logic [30:0] q;
  logic [30:0] r;
  logic [30:0] init_cov;
  logic signed [15:0] mx;
  logic signed [15:0] my;
  logic st;
  logic gain_ok;
  logic out_free;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic signed [31:0] cov_a;
  logic signed [31:0] cov_b;
  logic [32:0] s_den;
  logic s_pos;
  logic busy0;
  logic busy1;
  logic signed [31:0] q0;
  logic signed [31:0] q1;
  logic signed [31:0] k0;
  logic signed [31:0] k1;
  logic div_start;

  assign meas.ready = (state == S_IDLE);
  assign out_free = !pred.valid || pred.ready;
  assign k0 = gain_ok ? q0 : 32'sd0;
  assign k1 = gain_ok ? q1 : 32'sd0;
  assign div_start = (state == S_LAUNCH) && s_pos;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= cvkt_pkg::PROCESS_NOISE_RST;
      r <= cvkt_pkg::MEASURE_NOISE_RST;
      init_cov <= cvkt_pkg::INITIAL_COV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cvkt_pkg::REG_PROCESS_NOISE: q <= cfg_data;
        cvkt_pkg::REG_MEASURE_NOISE: r <= cfg_data;
        cvkt_pkg::REG_INITIAL_COV: init_cov <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (meas.valid) state_next = S_PRED;
      S_PRED:   if (out_free) state_next = S_LAUNCH;
      S_LAUNCH: state_next = S_DIV;
      S_DIV:    if (!busy0 && !busy1) state_next = S_MUL;
      S_MUL:    state_next = S_UPD;
      S_UPD:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.pred_en = (state == S_PRED) && out_free;
    ctl.start = st;
    ctl.err_en = (state == S_LAUNCH);
    ctl.mul_en = (state == S_MUL);
    ctl.upd_en = (state == S_UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (meas.valid && meas.ready) begin
      mx <= meas.meas_x;
      my <= meas.meas_y;
      st <= meas.start_req;
    end
    if (state == S_LAUNCH) begin
      gain_ok <= s_pos;
    end
  end

  // merge lane predictions into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pred.valid <= 1'b0;
    end else if (ctl.pred_en) begin
      pred.valid <= 1'b1;
    end else if (pred.ready) begin
      pred.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pred_en) begin
      pred.pred_x <= px;
      pred.pred_y <= py;
    end
  end

  cvkt_lane u_lane_x (
    .clk(clk), .rst(rst), .ctl(ctl), .meas(mx), .k0(k0), .k1(k1), .pred_int(px)
  );

  cvkt_lane u_lane_y (
    .clk(clk), .rst(rst), .ctl(ctl), .meas(my), .k0(k0), .k1(k1), .pred_int(py)
  );

  cvkt_cov u_cov (
    .clk(clk), .rst(rst), .ctl(ctl), .q(q), .r(r), .init_cov(init_cov),
    .k0(k0), .k1(k1), .cov_a(cov_a), .cov_b(cov_b), .s_den(s_den), .s_pos(s_pos)
  );

  cvkt_div u_div_k0 (
    .clk(clk), .rst(rst), .start(div_start), .num(cov_a), .den(s_den),
    .busy(busy0), .quo(q0)
  );

  cvkt_div u_div_k1 (
    .clk(clk), .rst(rst), .start(div_start), .num(cov_b), .den(s_den),
    .busy(busy1), .quo(q1)
  );

endmodule

// File: rtl/cvkt_checker.sv
// ----------------------------------------------------------------------------
// cvkt_checker
// Port-level checks of the tracker's transaction sequencing.
// ----------------------------------------------------------------------------
module cvkt_checker (
  input logic clk,
  input logic rst,
  input logic meas_valid,
  input logic meas_ready,
  input logic pred_valid,
  input logic pred_ready
);

  // one transaction in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    meas_valid && meas_ready |=> !meas_ready)
    else $error("input accepted while busy");

  // a new result only shows while the block is busy
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(pred_valid) |-> !meas_ready)
    else $error("result appeared while idle");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pred_valid)
    else $error("result valid after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pred_valid && !pred_ready |=> pred_valid)
    else $error("result dropped while stalled");

endmodule

bind constant_velocity_kalman_tracker cvkt_checker u_cvkt_checker (
  .clk(clk),
  .rst(rst),
  .meas_valid(meas.valid),
  .meas_ready(meas.ready),
  .pred_valid(pred.valid),
  .pred_ready(pred.ready)
);
